[rtl/mmm_pkg.sv]
// Shared types and constants of the matrix multiply core.
package mmm_pkg;

    localparam int ACT_W  = 2;
    localparam int IDX_W  = 3;
    localparam int DIM_W  = 4;
    localparam int ELEM_W = 16;
    localparam int SUM_W  = 40;

    localparam logic [1:0] REG_ROWS_A = 2'd0;
    localparam logic [1:0] REG_INNER  = 2'd1;
    localparam logic [1:0] REG_COLS_B = 2'd2;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD_A  = 2'd0,
        ACT_LOAD_B  = 2'd1,
        ACT_COMPUTE = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef struct packed {
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] inner;
        logic [DIM_W-1:0] cols;
    } dims_t;

endpackage

[rtl/mmm_if.sv]
// Request and result channel interfaces of the matrix multiply core.
interface mmm_cmd_if import mmm_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [ACT_W-1:0]         action;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [ELEM_W-1:0] element;

    modport source (output valid, action, row_index, col_index, element, input ready);
    modport sink (input valid, action, row_index, col_index, element, output ready);
endinterface

interface mmm_res_if import mmm_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [SUM_W-1:0] product_sum;
    logic                    last;

    modport source (output valid, out_row, out_col, product_sum, last, input ready);
    modport sink (input valid, out_row, out_col, product_sum, last, output ready);
endinterface

[rtl/mmm_store.sv]
// Operand store: one write port and one registered read port.
module mmm_store #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[rtl/mmm_engine.sv]
// Sequencer and multiply-accumulate pipeline that walks the stores and emits results.
module mmm_engine import mmm_pkg::*; #(
    parameter int MAX_DIM    = 8,
    parameter int DATA_WIDTH = 16,
    parameter int AW         = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  dims_t                 dims,
    output logic                  busy,
    output logic [AW-1:0]         raddr_a,
    output logic [AW-1:0]         raddr_b,
    input  logic [DATA_WIDTH-1:0] rdata_a,
    input  logic [DATA_WIDTH-1:0] rdata_b,
    mmm_res_if.source             res
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [DIM_W-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;

    logic v1_reg, first1_reg, last1_reg;
    logic v2_reg, first2_reg, last2_reg;
    logic done_reg;
    logic signed [2*DATA_WIDTH-1:0] prod_reg;
    logic signed [SUM_W-1:0] acc_reg;
    logic signed [SUM_W-1:0] prod_ext;

    logic out_valid_reg;
    logic [IDX_W-1:0] out_row_reg, out_col_reg;
    logic signed [SUM_W-1:0] out_sum_reg;
    logic out_last_reg;

    logic issue, last_k, last_i, last_j, slot_free, emit;

    assign last_k    = (k_reg == DIM_W'(dims.inner - 1'b1));
    assign last_i    = (i_reg == DIM_W'(dims.rows - 1'b1));
    assign last_j    = (j_reg == DIM_W'(dims.cols - 1'b1));
    assign issue     = (state_reg == S_RUN);
    assign slot_free = !out_valid_reg || res.ready;
    assign emit      = (state_reg == S_EMIT) && slot_free;
    assign busy      = (state_reg != S_IDLE);

    assign raddr_a = AW'(int'(i_reg) * MAX_DIM + int'(k_reg));
    assign raddr_b = AW'(int'(k_reg) * MAX_DIM + int'(j_reg));

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                k_next = k_reg + 1'b1;
                if (last_k)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (done_reg)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    k_next = '0;
                    if (last_j)
                    begin
                        j_next = '0;
                        if (last_i)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            i_next     = i_reg + 1'b1;
                            state_next = S_RUN;
                        end
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = S_RUN;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            done_reg  <= v2_reg && last2_reg;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign prod_ext = SUM_W'(prod_reg);

    always_ff @(posedge clk)
    begin
        first1_reg <= (k_reg == '0);
        last1_reg  <= last_k;
        first2_reg <= first1_reg;
        last2_reg  <= last1_reg;
        prod_reg   <= $signed(rdata_a) * $signed(rdata_b);
        if (v2_reg)
        begin
            acc_reg <= (first2_reg ? '0 : acc_reg) + prod_ext;
        end
        if (emit)
        begin
            out_row_reg  <= i_reg[IDX_W-1:0];
            out_col_reg  <= j_reg[IDX_W-1:0];
            out_sum_reg  <= acc_reg;
            out_last_reg <= last_i && last_j;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.out_row     = out_row_reg;
    assign res.out_col     = out_col_reg;
    assign res.product_sum = out_sum_reg;
    assign res.last        = out_last_reg;

endmodule

[rtl/matrix_matrix_multiply_core.sv]
// Top level of the matrix multiply core: configuration, load decode, stores and engine.
//
//   Channel   Direction  Contents
//   cmd       in         action, row_index, col_index, element
//   result    out        out_row, out_col, product_sum, last
//   cfg_*     in         write enable, register index, register data
//
// A load request writes its store and the block is ready for the next one at once.
// A compute request occupies the engine for all rows_a * cols_b results: each result
// is a serial dot product, one A and B operand pair read per cycle.
// New requests are refused until the last result has been placed in the output register.
// A stalled result holds the engine at that element; reset clears control state only.
module matrix_matrix_multiply_core import mmm_pkg::*; #(
    parameter int MAX_DIM    = 8,
    parameter int DATA_WIDTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    mmm_cmd_if.sink          cmd,
    mmm_res_if.source        result,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [DIM_W-1:0] cfg_data
);

    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DIM_CAP = (MAX_DIM > 15) ? 15 : MAX_DIM;

    dims_t dims_reg;
    logic [DIM_W-1:0] cfg_clamped;
    logic busy, accept, in_range, we_a, we_b, start;
    logic [AW-1:0] waddr, raddr_a, raddr_b;
    logic [DATA_WIDTH-1:0] wdata, rdata_a, rdata_b;

    always_comb
    begin
        if (cfg_data == '0)
        begin
            cfg_clamped = DIM_W'(1);
        end
        else if (int'(cfg_data) > DIM_CAP)
        begin
            cfg_clamped = DIM_W'(DIM_CAP);
        end
        else
        begin
            cfg_clamped = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg.rows  <= DIM_W'(DIM_CAP < 8 ? DIM_CAP : 8);
            dims_reg.inner <= DIM_W'(DIM_CAP < 8 ? DIM_CAP : 8);
            dims_reg.cols  <= DIM_W'(DIM_CAP < 8 ? DIM_CAP : 8);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROWS_A: dims_reg.rows  <= cfg_clamped;
                REG_INNER:  dims_reg.inner <= cfg_clamped;
                REG_COLS_B: dims_reg.cols  <= cfg_clamped;
                default:    dims_reg       <= dims_reg;
            endcase
        end
    end

    assign cmd.ready = !busy;
    assign accept    = cmd.valid && !busy;
    assign in_range  = (int'(cmd.row_index) < MAX_DIM) && (int'(cmd.col_index) < MAX_DIM);
    assign we_a      = accept && in_range && (cmd.action == ACT_LOAD_A);
    assign we_b      = accept && in_range && (cmd.action == ACT_LOAD_B);
    assign start     = accept && (cmd.action == ACT_COMPUTE);
    assign waddr     = AW'(int'(cmd.row_index) * MAX_DIM + int'(cmd.col_index));
    assign wdata     = DATA_WIDTH'($unsigned(cmd.element));

    mmm_store #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_WIDTH),
        .AW    (AW)
    ) u_store_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    mmm_store #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_WIDTH),
        .AW    (AW)
    ) u_store_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    mmm_engine #(
        .MAX_DIM    (MAX_DIM),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .dims    (dims_reg),
        .busy    (busy),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b),
        .res     (result)
    );

endmodule

[rtl/mmm_checker.sv]
// Port-level assertions for the matrix multiply core and their binding.
module mmm_checker import mmm_pkg::*; (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    cmd_valid,
    input logic                    cmd_ready,
    input logic [ACT_W-1:0]        cmd_action,
    input logic                    res_valid,
    input logic                    res_ready,
    input logic signed [SUM_W-1:0] res_sum,
    input logic                    res_last
);

    logic compute_req;

    assign compute_req = cmd_valid && cmd_ready && (cmd_action == ACT_COMPUTE);

    a_busy_after_compute: assert property (@(posedge clk) disable iff (!rst_n)
        compute_req |=> !cmd_ready)
        else $error("request channel still ready after a compute request");

    a_busy_only_from_compute: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(cmd_ready) |-> $past(compute_req))
        else $error("request channel went busy without a compute request");

    a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(cmd_ready) |-> (res_valid && res_last))
        else $error("engine returned to idle without presenting the last result");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_sum) && $stable(res_last)))
        else $error("stalled result changed or was dropped");

endmodule

bind matrix_matrix_multiply_core mmm_checker u_mmm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .cmd_action (cmd.action),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_sum    (result.product_sum),
    .res_last   (result.last)
);
